/* sv/aard_pkg.sv */
// package: types, constants and register codes for the row area-average downscaler
package aard_pkg;

   localparam int FracBits = 16;
   localparam int MaxRow   = 4096;
   localparam int LenW     = 13;
   localparam int StepW    = 15;
   localparam int InvW     = 29;
   localparam int CntW     = 12;
   localparam int PosW     = 28;
   localparam int BndW     = 29;
   localparam int SumW     = 37;
   localparam int WgtW     = 29;
   localparam int FracW    = FracBits + 1;
   localparam int QuoW     = 9;
   localparam logic [WgtW-1:0] FixOne = WgtW'(1) << FracBits;

   typedef enum logic [1:0] {
      CSR_SOURCE_LENGTH = 2'd0,
      CSR_STEP_RATIO    = 2'd1,
      CSR_INVERSE_RATIO = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]      red_out;
      logic [7:0]      green_out;
      logic [7:0]      blue_out;
      logic [7:0]      alpha_out;
      logic [CntW-1:0] target_position;
      logic            row_done;
   } rsp_payload_type;

   // work handed from front to back: sums are final, ready to divide
   typedef struct packed {
      logic [3:0][SumW-1:0] sums;
      logic [WgtW-1:0]      weight;
      logic [CntW-1:0]      target;
      logic                 row_done;
   } div_job_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_DIV  = 2'd1,
      BK_OUT  = 2'd2
   } back_state_type;

   typedef enum logic [1:0] {
      FR_IDLE = 2'd0,
      FR_MUL  = 2'd1,
      FR_ACC  = 2'd2
   } front_state_type;

endpackage

/* sv/aard_front.sv */
// front: accumulates pixels, computes the split fraction, hands jobs to the queue
module aard_front import aard_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   input  logic [LenW-1:0]   len_cfg,
   input  logic [StepW-1:0]  step_cfg,
   input  logic [InvW-1:0]   inv_cfg,
   output logic              job_valid,
   input  logic              job_full,
   output div_job_type       job_data
);

   front_state_type state_ff, state_in;
   logic [CntW-1:0]      src_cnt_ff, tgt_cnt_ff;
   logic [PosW-1:0]      pos_ff;
   logic [BndW-1:0]      bnd_ff;
   logic [3:0][SumW-1:0] sum_ff;
   logic [WgtW-1:0]      wgt_ff;
   req_payload_type      pix_ff;
   logic                 last_ff;
   logic [PosW-1:0]      end_ff;
   logic [FracW+InvW-1:0] prod_ff;

   logic [LenW-1:0] len_eff;
   logic            last_w;
   logic [BndW:0]   end_w;
   logic [BndW-1:0] diff_w;
   logic [FracW-1:0] diff_cap;
   logic [FracW+InvW-FracBits-1:0] frac_raw;
   logic [FracW-1:0] frac_w, rest_w;
   logic [7:0] pix_ch [4];
   logic [7:0] in_ch [4];
   logic accept;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != FR_IDLE);
   assign job_valid = (state_ff == FR_ACC) && !job_full;

   assign in_ch[0] = req_payload.red_in;
   assign in_ch[1] = req_payload.green_in;
   assign in_ch[2] = req_payload.blue_in;
   assign in_ch[3] = req_payload.alpha_in;
   assign pix_ch[0] = pix_ff.red_in;
   assign pix_ch[1] = pix_ff.green_in;
   assign pix_ch[2] = pix_ff.blue_in;
   assign pix_ch[3] = pix_ff.alpha_in;

   // classify the incoming pixel
   always_comb begin
      len_eff = len_cfg;
      if (len_cfg == '0) len_eff = LenW'(1);
      if (len_cfg > LenW'(MaxRow)) len_eff = LenW'(MaxRow);
      last_w = ({1'b0, src_cnt_ff} + 13'd1) >= len_eff;
      end_w  = (BndW+1)'(pos_ff) + (BndW+1)'(step_cfg);
      diff_w = (bnd_ff > BndW'(pos_ff)) ? bnd_ff - BndW'(pos_ff) : '0;
      diff_cap = (diff_w > BndW'(FixOne)) ? FracW'(FixOne) : diff_w[FracW-1:0];
   end

   // fraction from the registered product
   always_comb begin
      frac_raw = prod_ff[FracW+InvW-1:FracBits];
      frac_w = (frac_raw > (FracW+InvW-FracBits)'(FixOne)) ? FracW'(FixOne)
                                                            : frac_raw[FracW-1:0];
      rest_w = FracW'(FixOne) - frac_w;
   end

   // job payload: final sums with the split pixel added
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         job_data.sums[k] = sum_ff[k] + SumW'(pix_ch[k]) * SumW'(frac_w);
      end
      job_data.weight   = wgt_ff + WgtW'(frac_w);
      job_data.target   = tgt_cnt_ff;
      job_data.row_done = last_ff;
   end

   // sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: if (accept && (last_w || end_w < (BndW+1)'(bnd_ff))) begin
            if (last_w || end_w >= (BndW+1)'(bnd_ff)) state_in = FR_MUL;
         end else if (accept) begin
            state_in = FR_MUL;
         end
         FR_MUL: state_in = FR_ACC;
         FR_ACC: if (!job_full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
      if (state_ff == FR_IDLE && accept && !last_w && end_w < (BndW+1)'(bnd_ff))
         state_in = FR_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_IDLE;
         src_cnt_ff <= '0;
         tgt_cnt_ff <= '0;
         pos_ff     <= '0;
         bnd_ff     <= BndW'(FixOne);
         sum_ff     <= '0;
         wgt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            FR_IDLE: if (accept) begin
               pix_ff  <= req_payload;
               last_ff <= last_w;
               end_ff  <= end_w[PosW-1:0];
               prod_ff <= (FracW+InvW)'(diff_cap) * (FracW+InvW)'(inv_cfg);
               if (!last_w && end_w < (BndW+1)'(bnd_ff)) begin
                  for (int k = 0; k < 4; k++)
                     sum_ff[k] <= sum_ff[k] + (SumW'(in_ch[k]) << FracBits);
                  wgt_ff     <= wgt_ff + FixOne;
                  pos_ff     <= end_w[PosW-1:0];
                  src_cnt_ff <= src_cnt_ff + 1'b1;
               end
            end
            FR_ACC: if (!job_full) begin
               if (last_ff) begin
                  src_cnt_ff <= '0;
                  tgt_cnt_ff <= '0;
                  pos_ff     <= '0;
                  bnd_ff     <= BndW'(FixOne);
                  sum_ff     <= '0;
                  wgt_ff     <= '0;
               end else begin
                  for (int k = 0; k < 4; k++)
                     sum_ff[k] <= SumW'(pix_ch[k]) * SumW'(rest_w);
                  wgt_ff     <= WgtW'(rest_w);
                  bnd_ff     <= bnd_ff + BndW'(FixOne);
                  tgt_cnt_ff <= tgt_cnt_ff + 1'b1;
                  pos_ff     <= end_ff;
                  src_cnt_ff <= src_cnt_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

/* sv/aard_queue.sv */
// queue: two-entry fifo of division jobs between front and back
module aard_queue import aard_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  div_job_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output div_job_type pop_data
);

   div_job_type     mem_ff [2];
   logic            wp_ff, rp_ff;
   logic [1:0]      cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* sv/aard_back.sv */
// back: restoring division of four channel sums by the weight, with output register
module aard_back import aard_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  div_job_type     job_data,
   output logic            job_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int RemW = WgtW + 1;
   localparam int NumW = SumW + 1;
   localparam int StepCnt = NumW;

   back_state_type state_ff, state_in;
   logic [3:0][NumW-1:0] num_ff;
   logic [3:0][RemW-1:0] rem_ff;
   logic [3:0][QuoW-1:0] quo_ff;
   logic [WgtW-1:0]      div_ff;
   logic [5:0]           step_ff;
   logic [CntW-1:0]      tgt_ff;
   logic                 done_ff;
   logic [3:0][RemW-1:0] rem_in;
   logic [3:0]           qbit;
   logic [7:0]           ch [4];

   assign job_pop   = (state_ff == BK_IDLE) && job_valid;
   assign rsp_valid = (state_ff == BK_OUT);

   // one quotient bit per cycle for each channel
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic [RemW:0] trial;
         trial = {rem_ff[k], num_ff[k][NumW-1]};
         qbit[k] = trial >= (RemW+1)'(div_ff);
         rem_in[k] = qbit[k] ? RemW'(trial - (RemW+1)'(div_ff)) : RemW'(trial);
      end
   end

   // saturate and zero-weight handling
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (div_ff == '0) ch[k] = 8'd0;
         else if (quo_ff[k][QuoW-1]) ch[k] = 8'hFF;
         else ch[k] = quo_ff[k][7:0];
      end
      rsp_payload.red_out         = ch[0];
      rsp_payload.green_out       = ch[1];
      rsp_payload.blue_out        = ch[2];
      rsp_payload.alpha_out       = ch[3];
      rsp_payload.target_position = tgt_ff;
      rsp_payload.row_done        = done_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (job_valid) state_in = BK_DIV;
         BK_DIV:  if (step_ff == 6'(StepCnt - 1)) state_in = BK_OUT;
         BK_OUT:  if (!rsp_stall) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_IDLE) step_ff <= '0;
         else if (state_ff == BK_DIV) step_ff <= step_ff + 6'd1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && job_valid) begin
         for (int k = 0; k < 4; k++) begin
            num_ff[k] <= NumW'(job_data.sums[k]) + NumW'(job_data.weight >> 1);
            rem_ff[k] <= '0;
            quo_ff[k] <= '0;
         end
         div_ff  <= job_data.weight;
         tgt_ff  <= job_data.target;
         done_ff <= job_data.row_done;
      end else if (state_ff == BK_DIV) begin
         for (int k = 0; k < 4; k++) begin
            num_ff[k] <= num_ff[k] << 1;
            rem_ff[k] <= rem_in[k];
            // any bit beyond the low eight marks saturation
            quo_ff[k] <= {quo_ff[k][QuoW-1] | quo_ff[k][QuoW-2],
                          quo_ff[k][QuoW-3:0], qbit[k]};
         end
      end
   end

endmodule

/* sv/area_average_row_downscale.sv */
// top level of the horizontal area-average row downscaler
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | req_payload_type (rgba pixel)
//  rsp     | out       | rsp_valid/stall  | rsp_payload_type (pixel, index, row_done)
//  csr     | in        | csr_valid/ready  | csr_index, csr_data
// a pixel inside the target cell is taken without leaving the idle state; a boundary pixel
// passes the front states accept, multiply and hand-off, then the back divider steps
// load, quotient steps and output, where the result waits under rsp_stall.
// the back serial divider (one quotient bit per cycle) sets throughput of emitting pixels.
// reset is synchronous and clears row state, state machines and config registers to their defaults.
// req_stall rises while the front works a split pixel, including while it waits on a full queue.
module area_average_row_downscale import aard_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_data
);

   logic [LenW-1:0]  len_ff;
   logic [StepW-1:0] step_ff;
   logic [InvW-1:0]  inv_ff;
   logic        push, full, pop, not_empty;
   div_job_type push_data, pop_data;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LenW'(1);
         step_ff <= StepW'(16384);
         inv_ff  <= InvW'(262144);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_LENGTH: len_ff  <= csr_data[LenW-1:0];
            CSR_STEP_RATIO:    step_ff <= csr_data[StepW-1:0];
            CSR_INVERSE_RATIO: inv_ff  <= csr_data[InvW-1:0];
            default: ;
         endcase
      end
   end

   aard_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .len_cfg(len_ff), .step_cfg(step_ff), .inv_cfg(inv_ff),
      .job_valid(push), .job_full(full), .job_data(push_data)
   );

   aard_queue u_queue (
      .clock, .reset, .push, .push_data, .full,
      .pop, .not_empty, .pop_data
   );

   aard_back u_back (
      .clock, .reset, .job_valid(not_empty), .job_data(pop_data), .job_pop(pop),
      .rsp_valid, .rsp_stall, .rsp_payload
   );

endmodule

/* sv/aard_checker.sv */
// port-level checker for the downscaler, bound to the top level
module aard_checker import aard_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed under stall");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

   // a result transfer never repeats on the next cycle
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("back-to-back result");

   // a row closing result transfer is not followed straight away by another result
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.row_done |=> !rsp_valid)
      else $error("row close followed by result");

   // input stall is always known while a pixel is offered
   a_req_stall_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_stall))
      else $error("unknown input stall");

endmodule

bind area_average_row_downscale aard_checker u_aard_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_payload
);
